[rtl/core/set_assoc_writeback_cache_tags_macros.svh]
// Assertion macros shared by the cache tag controller RTL.
`ifndef SET_ASSOC_WRITEBACK_CACHE_TAGS_MACROS_SVH
`define SET_ASSOC_WRITEBACK_CACHE_TAGS_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SAWC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define SAWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sawc_pkg.sv]
// Shared types, constants and helper functions of the cache tag controller.
package sawc_pkg;

    localparam int ADDR_W = 32;
    localparam int OUT_WAY_W = 2;
    localparam int LFSR_W = 16;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } sawc_state_t;

    typedef struct packed {
        logic capture;
        logic clear_step;
        logic commit;
    } sawc_cmd_t;

    typedef struct packed {
        logic clear_last;
    } sawc_status_t;

    function automatic int floor_log2(input int value);
        int v;
        int n;
        v = value;
        n = 0;
        while (v > 1) begin
            v = v >> 1;
            n = n + 1;
        end
        return n;
    endfunction

    // One Galois step of the replacement LFSR.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] t;
        t = s >> 1;
        if (s[0])
        begin
            t = t ^ LFSR_TAPS;
        end
        return t;
    endfunction

endpackage

[rtl/core/sawc_ram.sv]
// Generic single-port RAM with registered read.
module sawc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/sawc_ctrl.sv]
// Sequencer: clearing pass, access capture, lookup and result handoff.
module sawc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  sawc_pkg::sawc_status_t status,
    output sawc_pkg::sawc_cmd_t    cmd
);

    import sawc_pkg::*;

    sawc_state_t state_reg;
    sawc_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // hold the set row until the result slot frees up
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/core/sawc_dp.sv]
// Datapath: tag and metadata RAMs, way compare, victim choice, row update.
module sawc_dp #(
    parameter int LINE_BYTES = 64,
    parameter int WAYS       = 4,
    parameter int SETS       = 1024,
    parameter int ADDR_BITS  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sawc_pkg::sawc_cmd_t              cmd,
    output sawc_pkg::sawc_status_t           status,
    input  logic                             cfg_valid,
    input  logic                             cfg_data,
    input  logic                             operation,
    input  logic [sawc_pkg::ADDR_W-1:0]      address,
    output logic                             hit,
    output logic [sawc_pkg::OUT_WAY_W-1:0]   way,
    output logic                             writeback,
    output logic [sawc_pkg::ADDR_W-1:0]      writeback_address
);

    import sawc_pkg::*;

    localparam int OFF_BITS = floor_log2(LINE_BYTES);
    localparam int SET_BITS = floor_log2(SETS);
    localparam int LOW_BITS = OFF_BITS + SET_BITS;
    localparam int TAG_BITS = (ADDR_BITS > LOW_BITS) ? (ADDR_BITS - LOW_BITS) : 0;
    localparam int TAG_W    = (TAG_BITS > 0) ? TAG_BITS : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W    = WAY_W;
    localparam int META_W   = 2 + AGE_W;
    localparam int ROWS     = 1 << SET_BITS;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);
    // ceil(2^32 / WAYS): exact quotient for any 16-bit value
    localparam longint unsigned RECIP = ((64'd1 << 32) + 64'(WAYS) - 64'd1) / 64'(WAYS);
    localparam int PROD_W = LFSR_W + 33;
    localparam int REM_W  = LFSR_W + 5;

    // captured access
    logic                op_reg;
    logic [SET_BITS-1:0] set_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [63:0]         addr_shift;
    logic [TAG_W-1:0]    in_tag;

    logic                replacement_mode_reg;
    logic [SET_BITS-1:0] clr_cnt_reg;

    logic [LFSR_W-1:0]   lfsr_reg;
    logic [LFSR_W-1:0]   step_reg;
    logic [LFSR_W-1:0]   quot_reg;
    logic [PROD_W-1:0]   prod;
    logic [REM_W-1:0]    rem_full;
    logic [WAY_W-1:0]    rand_way;

    logic [SET_BITS-1:0]       ram_addr;
    logic [WAYS*TAG_W-1:0]     tag_rd;
    logic [WAYS*TAG_W-1:0]     tag_wr;
    logic [WAYS*META_W-1:0]    meta_rd;
    logic [WAYS*META_W-1:0]    meta_wr;
    logic [WAYS*META_W-1:0]    meta_new;
    logic                      meta_we;

    logic [WAYS-1:0]             valid_cur;
    logic [WAYS-1:0]             dirty_cur;
    logic [WAYS-1:0][AGE_W-1:0]  age_cur;
    logic [WAYS-1:0][TAG_W-1:0]  tag_cur;
    logic [WAYS-1:0]             valid_new;
    logic [WAYS-1:0]             dirty_new;
    logic [WAYS-1:0][AGE_W-1:0]  age_new;
    logic [WAYS-1:0][TAG_W-1:0]  tag_new;

    logic             hit_any;
    logic [WAY_W-1:0] hit_way;
    logic             free_any;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] lru_way;
    logic [AGE_W-1:0] lru_best;
    logic [WAY_W-1:0] fill_way;
    logic [WAY_W-1:0] way_sel;
    logic             lru_mode;
    logic             wb_any;
    logic             rand_used;
    logic [63:0]      wb_ext;
    logic [3:0]       way_ext;

    assign addr_shift = 64'(address) >> LOW_BITS;
    assign in_tag     = (TAG_BITS > 0) ? addr_shift[TAG_W-1:0] : '0;
    assign lru_mode   = !replacement_mode_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            set_reg <= address[OFF_BITS +: SET_BITS];
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replacement_mode_reg <= 1'b0;
            clr_cnt_reg          <= '0;
            lfsr_reg             <= LFSR_SEED;
        end
        else
        begin
            if (cfg_valid)
            begin
                replacement_mode_reg <= cfg_data;
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_BITS'(1);
            end
            if (cmd.commit && rand_used)
            begin
                lfsr_reg <= step_reg;
            end
        end
    end

    assign status.clear_last = (clr_cnt_reg == {SET_BITS{1'b1}});

    // precompute the next LFSR value and its quotient by WAYS
    assign prod = PROD_W'(lfsr_step(lfsr_reg)) * PROD_W'(RECIP[32:0]);

    always_ff @(posedge clk)
    begin
        step_reg <= lfsr_step(lfsr_reg);
        quot_reg <= prod[32 +: LFSR_W];
    end

    assign rem_full = REM_W'(step_reg) - (REM_W'(quot_reg) * REM_W'(WAYS));
    assign rand_way = rem_full[WAY_W-1:0];

    always_comb
    begin
        if (cmd.clear_step)
        begin
            ram_addr = clr_cnt_reg;
        end
        else if (cmd.capture)
        begin
            ram_addr = address[OFF_BITS +: SET_BITS];
        end
        else
        begin
            ram_addr = set_reg;
        end
    end

    assign meta_we = cmd.clear_step || cmd.commit;
    assign meta_wr = cmd.clear_step ? '0 : meta_new;

    sawc_ram #(
        .WIDTH (WAYS * TAG_W),
        .DEPTH (ROWS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .addr  (ram_addr),
        .wdata (tag_wr),
        .rdata (tag_rd)
    );

    sawc_ram #(
        .WIDTH (WAYS * META_W),
        .DEPTH (ROWS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .addr  (ram_addr),
        .wdata (meta_wr),
        .rdata (meta_rd)
    );

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            valid_cur[w] = meta_rd[w*META_W];
            dirty_cur[w] = meta_rd[w*META_W + 1];
            age_cur[w]   = meta_rd[w*META_W + 2 +: AGE_W];
            tag_cur[w]   = tag_rd[w*TAG_W +: TAG_W];
        end

        // lowest matching way and lowest free way
        hit_any  = 1'b0;
        hit_way  = '0;
        free_any = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (valid_cur[w] && (tag_cur[w] == tag_reg))
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!valid_cur[w])
            begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
        end

        // oldest way, highest index on a tie
        lru_best = '0;
        lru_way  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (age_cur[w] >= lru_best)
            begin
                lru_best = age_cur[w];
                lru_way  = WAY_W'(w);
            end
        end

        rand_used = !hit_any && !free_any && !lru_mode;
        if (free_any)
        begin
            fill_way = free_way;
        end
        else if (lru_mode)
        begin
            fill_way = lru_way;
        end
        else
        begin
            fill_way = rand_way;
        end
        way_sel = hit_any ? hit_way : fill_way;

        wb_any = !hit_any && !free_any && dirty_cur[fill_way];
        wb_ext = (64'(tag_cur[fill_way]) << LOW_BITS) | (64'(set_reg) << OFF_BITS);

        valid_new = valid_cur;
        dirty_new = dirty_cur;
        age_new   = age_cur;
        tag_new   = tag_cur;
        if (hit_any)
        begin
            if (lru_mode)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (valid_cur[w] && (age_cur[w] < age_cur[hit_way]))
                    begin
                        age_new[w] = age_cur[w] + AGE_W'(1);
                    end
                end
                age_new[hit_way] = '0;
            end
            if (op_reg)
            begin
                dirty_new[hit_way] = 1'b1;
            end
        end
        else
        begin
            valid_new[fill_way] = 1'b1;
            dirty_new[fill_way] = op_reg;
            tag_new[fill_way]   = tag_reg;
            if (lru_mode)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if ((WAY_W'(w) != fill_way) && valid_cur[w] && (age_cur[w] < AGE_MAX))
                    begin
                        age_new[w] = age_cur[w] + AGE_W'(1);
                    end
                end
                age_new[fill_way] = '0;
            end
        end

        for (int w = 0; w < WAYS; w++)
        begin
            meta_new[w*META_W +: META_W] = {age_new[w], dirty_new[w], valid_new[w]};
            tag_wr[w*TAG_W +: TAG_W]     = tag_new[w];
        end
    end

    assign way_ext = 4'(way_sel);

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit               <= hit_any;
            way               <= way_ext[OUT_WAY_W-1:0];
            writeback         <= wb_any;
            writeback_address <= wb_any ? wb_ext[ADDR_W-1:0] : '0;
        end
    end

endmodule

[rtl/core/set_assoc_writeback_cache_tags.sv]
// Top level of the set-associative write-back cache tag and replacement controller.
//
//  channel | signals                                        | dir | transaction
//  --------+------------------------------------------------+-----+---------------------------
//  in      | in_valid, in_ready, operation, address         | in  | one load or store access
//  out     | out_valid, out_ready, hit, way, writeback,     | out | one result per access
//          | writeback_address                              |     |
//  cfg     | cfg_valid, cfg_ready, cfg_data                 | in  | replacement mode write
//
// An access reads the set row synchronously from the tag and metadata RAMs, then
// compares and writes back the updated row on one RAM port.
// After reset a clearing pass zeroes all 2^floor(log2(SETS)) rows of the metadata RAM
// (1024 by default), with in_ready low; cfg writes are taken throughout.
// A result waits in the output register; the next access is accepted meanwhile and
// holds in lookup until that result is taken.
`include "set_assoc_writeback_cache_tags_macros.svh"

module set_assoc_writeback_cache_tags #(
    parameter int LINE_BYTES = 64,
    parameter int WAYS       = 4,
    parameter int SETS       = 1024,
    parameter int ADDR_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           operation,
    input  logic [sawc_pkg::ADDR_W-1:0]    address,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           hit,
    output logic [sawc_pkg::OUT_WAY_W-1:0] way,
    output logic                           writeback,
    output logic [sawc_pkg::ADDR_W-1:0]    writeback_address
);

    import sawc_pkg::*;

    sawc_cmd_t    cmd;
    sawc_status_t status;

    assign cfg_ready = 1'b1;

    sawc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sawc_dp #(
        .LINE_BYTES (LINE_BYTES),
        .WAYS       (WAYS),
        .SETS       (SETS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_valid         (cfg_valid && cfg_ready),
        .cfg_data          (cfg_data),
        .operation         (operation),
        .address           (address),
        .hit               (hit),
        .way               (way),
        .writeback         (writeback),
        .writeback_address (writeback_address)
    );

    `SAWC_ASSERT_NEXT(a_one_access, clk, rst_n, in_valid && in_ready, !in_ready, "access accepted during lookup")
    `SAWC_ASSERT_NEXT(a_commit_result, clk, rst_n, cmd.commit, out_valid, "committed access left no result")
    `SAWC_ASSERT_IMP(a_hit_no_wb, clk, rst_n, out_valid && hit, !writeback, "writeback reported on a hit")
    `SAWC_ASSERT_IMP(a_wb_addr_zero, clk, rst_n, out_valid && !writeback, writeback_address == '0, "writeback address set without writeback")

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the set-associative write-back cache tag controller.
module tb_top;

    localparam int  NUM_SETS     = 1024;
    localparam int  NUM_WAYS     = 4;
    localparam int  OFFSET_W     = 6;
    localparam int  SET_W        = 10;
    localparam int  TAG_W        = 16;
    localparam logic [15:0] SHIFT_SEED = 16'hACE1;
    localparam logic [15:0] SHIFT_TAPS = 16'hB400;
    localparam logic MODE_LRU    = 1'b0;
    localparam logic MODE_RANDOM = 1'b1;
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_STORE    = 1'b1;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  DRAIN_LIMIT  = 5000;
    localparam int  SETTLE_CYCLES = 20;

    typedef struct packed {
        logic                         hit;
        logic [1:0]                   way;
        logic                         writeback;
        logic [sawc_pkg::ADDR_W-1:0]  writeback_address;
    } access_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic operation = 1'b0;
    logic [sawc_pkg::ADDR_W-1:0] address = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;
    logic [sawc_pkg::OUT_WAY_W-1:0] way;
    logic writeback;
    logic [sawc_pkg::ADDR_W-1:0] writeback_address;

    // Cache state as the controller should hold it.
    logic [TAG_W-1:0] stored_tag [NUM_SETS][NUM_WAYS];
    bit               way_valid  [NUM_SETS][NUM_WAYS];
    bit               way_dirty  [NUM_SETS][NUM_WAYS];
    logic [1:0]       way_age    [NUM_SETS][NUM_WAYS];
    logic [15:0]      victim_shift;
    logic             replacement_random;

    access_result_t pending_results [$];
    int  mismatches = 0;
    int  sender_idle_pct = 0;
    int  receiver_idle_pct = 0;
    int  hold_cycles = 0;
    bit  offering = 1'b0;

    set_assoc_writeback_cache_tags dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .address          (address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .hit              (hit),
        .way              (way),
        .writeback        (writeback),
        .writeback_address(writeback_address)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic clear_cache_model();
        int s;
        int w;
        for (s = 0; s < NUM_SETS; s++)
        begin
            for (w = 0; w < NUM_WAYS; w++)
            begin
                stored_tag[s][w] = '0;
                way_valid[s][w] = 1'b0;
                way_dirty[s][w] = 1'b0;
                way_age[s][w] = '0;
            end
        end
        victim_shift = SHIFT_SEED;
        replacement_random = MODE_LRU;
    endtask

    // Look up one access, update the tag state and return what the controller reports.
    function automatic access_result_t lookup_and_update(input logic store,
                                                         input logic [31:0] addr);
        access_result_t   r;
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        logic [1:0]       oldest;
        int               w;
        int               pick;
        bit               found;
        bit               free_found;
        set_idx = addr[OFFSET_W +: SET_W];
        tag = addr[OFFSET_W + SET_W +: TAG_W];
        r = '0;
        found = 1'b0;
        pick = 0;
        for (w = 0; w < NUM_WAYS; w++)
        begin
            if (!found && way_valid[set_idx][w] && stored_tag[set_idx][w] == tag)
            begin
                found = 1'b1;
                pick = w;
            end
        end
        if (found)
        begin
            if (replacement_random == MODE_LRU)
            begin
                oldest = way_age[set_idx][pick];
                for (w = 0; w < NUM_WAYS; w++)
                begin
                    if (way_valid[set_idx][w] && way_age[set_idx][w] < oldest)
                        way_age[set_idx][w] = way_age[set_idx][w] + 2'd1;
                end
                way_age[set_idx][pick] = '0;
            end
            if (store == OP_STORE)
                way_dirty[set_idx][pick] = 1'b1;
            r.hit = 1'b1;
        end
        else
        begin
            free_found = 1'b0;
            for (w = 0; w < NUM_WAYS; w++)
            begin
                if (!free_found && !way_valid[set_idx][w])
                begin
                    free_found = 1'b1;
                    pick = w;
                end
            end
            if (!free_found)
            begin
                if (replacement_random == MODE_LRU)
                begin
                    // ties go to the highest-numbered way
                    oldest = '0;
                    for (w = 0; w < NUM_WAYS; w++)
                    begin
                        if (way_age[set_idx][w] >= oldest)
                        begin
                            oldest = way_age[set_idx][w];
                            pick = w;
                        end
                    end
                end
                else
                begin
                    victim_shift = {1'b0, victim_shift[15:1]}
                                   ^ (victim_shift[0] ? SHIFT_TAPS : 16'h0000);
                    pick = victim_shift % NUM_WAYS;
                end
                if (way_dirty[set_idx][pick])
                begin
                    r.writeback = 1'b1;
                    r.writeback_address = {stored_tag[set_idx][pick], set_idx,
                                           {OFFSET_W{1'b0}}};
                end
            end
            stored_tag[set_idx][pick] = tag;
            way_valid[set_idx][pick] = 1'b1;
            way_dirty[set_idx][pick] = (store == OP_STORE);
            if (replacement_random == MODE_LRU)
            begin
                for (w = 0; w < NUM_WAYS; w++)
                begin
                    if (w != pick && way_valid[set_idx][w] && way_age[set_idx][w] < 2'd3)
                        way_age[set_idx][w] = way_age[set_idx][w] + 2'd1;
                end
                way_age[set_idx][pick] = '0;
            end
        end
        r.way = pick[1:0];
        return r;
    endfunction

    // Mostly addresses from eight sets and six tags, so that hits and evictions are common.
    function automatic logic [31:0] pick_address();
        logic [2:0] j;
        logic [2:0] k;
        logic [SET_W-1:0] s;
        logic [TAG_W-1:0] t;
        logic [OFFSET_W-1:0] o;
        if ($urandom_range(0, 99) < 15)
            return $urandom;
        j = 3'($urandom_range(0, 7));
        k = 3'($urandom_range(0, 5));
        s = j[0] ? ~{7'h00, j} : {7'h00, j};
        t = k[0] ? ~{13'h0000, k} : {13'h0000, k};
        o = OFFSET_W'($urandom_range(0, 63));
        return {t, s, o};
    endfunction

    function automatic logic [31:0] line_address(input logic [TAG_W-1:0] t,
                                                 input logic [SET_W-1:0] s);
        return {t, s, {OFFSET_W{1'b0}}};
    endfunction

    task automatic send_access(input logic op, input logic [31:0] addr);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < sender_idle_pct)
            gap = $urandom_range(1, 5);
        if (gap > 0 && offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        operation <= op;
        address <= addr;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(lookup_and_update(op, addr));
    endtask

    task automatic stop_sending();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        replacement_random = mode;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_lru();
        int i;
        write_mode(MODE_LRU);
        send_access(OP_LOAD, 32'h0000_0000);
        send_access(OP_STORE, 32'hFFFF_FFFF);
        send_access(OP_LOAD, 32'hFFFF_FFC0);
        send_access(OP_STORE, 32'h0000_003F);
        send_access(OP_LOAD, 32'h8000_0000);
        send_access(OP_STORE, 32'h7FFF_FFFF);
        // fill one set with dirty lines, reorder by a hit, then evict twice
        for (i = 0; i < NUM_WAYS; i++)
            send_access(OP_STORE, line_address(16'(16'h1000 + i), 10'd5));
        send_access(OP_LOAD, line_address(16'h1000, 10'd5) | 32'h15);
        send_access(OP_LOAD, line_address(16'h2000, 10'd5));
        send_access(OP_STORE, line_address(16'h2001, 10'd5));
        send_access(OP_LOAD, line_address(16'h1003, 10'd5));
        stop_sending();
        wait_drained();
    endtask

    task automatic test_directed_random();
        int i;
        write_mode(MODE_RANDOM);
        for (i = 0; i < NUM_WAYS; i++)
            send_access(OP_STORE, line_address(16'(16'hFFF0 + i), 10'd9));
        for (i = 0; i < NUM_WAYS; i++)
            send_access(OP_LOAD, line_address(16'(16'h0300 + i), 10'd9));
        send_access(OP_STORE, line_address(16'h0301, 10'd9));
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input logic mode);
        int i;
        write_mode(mode);
        for (i = 0; i < count; i++)
            send_access(1'($urandom_range(0, 1)), pick_address());
        stop_sending();
        wait_drained();
    endtask

    task automatic test_output_hold();
        int i;
        hold_cycles = HOLD_CYCLES;
        for (i = 0; i < 30; i++)
            send_access(1'($urandom_range(0, 1)), pick_address());
        stop_sending();
        wait_drained();
    endtask

    task automatic test_pause_until_drained();
        int i;
        for (i = 0; i < 10; i++)
            send_access(1'($urandom_range(0, 1)), pick_address());
        stop_sending();
        wait_drained();
        for (i = 0; i < 10; i++)
            send_access(1'($urandom_range(0, 1)), pick_address());
        stop_sending();
        wait_drained();
    endtask

    // Receiver: random back-pressure, plus a long hold when a test asks for one.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        access_result_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no access pending");
                mismatches++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (hit !== exp.hit)
                begin
                    $error("hit: expected %0d, got %0d", exp.hit, hit);
                    mismatches++;
                end
                if (way !== exp.way)
                begin
                    $error("way: expected %0d, got %0d", exp.way, way);
                    mismatches++;
                end
                if (writeback !== exp.writeback)
                begin
                    $error("writeback: expected %0d, got %0d", exp.writeback, writeback);
                    mismatches++;
                end
                if (writeback_address !== exp.writeback_address)
                begin
                    $error("writeback_address: expected %h, got %h",
                           exp.writeback_address, writeback_address);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int c;
        clear_cache_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_lru();
        test_directed_random();

        sender_idle_pct = 37;
        receiver_idle_pct = 72;
        test_random_traffic(200, MODE_LRU);
        test_random_traffic(200, MODE_RANDOM);
        test_output_hold();

        sender_idle_pct = 72;
        receiver_idle_pct = 37;
        test_random_traffic(200, MODE_LRU);
        test_random_traffic(200, MODE_RANDOM);
        test_pause_until_drained();

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_random_traffic(125, MODE_RANDOM);
        test_random_traffic(125, MODE_LRU);
        test_output_hold();

        for (c = 0; c < DRAIN_LIMIT && pending_results.size() != 0; c++)
            @(posedge clk);
        mismatches += pending_results.size();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
